// ----- rtl/mpct_pkg.sv -----
// Package for the mouse packet cursor tracker.
// Holds field widths, status and header bit positions, cursor sizes and register indexes.
// No dependencies.
package mpct_pkg;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 10;
  localparam int DELTA_W  = BYTE_W + 1;
  localparam int SUM_W    = POS_W + 2;
  localparam int CNT_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 2 * BYTE_W;
  localparam int OUT_FIELD_W = 2 * POS_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Controller status bits and the header sync bit.
  localparam int STAT_READY_BIT = 0;
  localparam int STAT_AUX_BIT   = 5;
  localparam int HDR_SYNC_BIT   = 3;

  // Cursor footprint and reset values.
  localparam logic [POS_W-1:0] CURSOR_W     = POS_W'(8);
  localparam logic [POS_W-1:0] CURSOR_H     = POS_W'(12);
  localparam logic [POS_W-1:0] WIDTH_RST    = POS_W'(320);
  localparam logic [POS_W-1:0] HEIGHT_RST   = POS_W'(200);
  localparam logic [POS_W-1:0] POS_X_RST    = POS_W'(160);
  localparam logic [POS_W-1:0] POS_Y_RST    = POS_W'(100);

  // Packet byte positions.
  localparam logic [CNT_W-1:0] CNT_HEADER = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_DX     = CNT_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/mpct_axis_step.sv -----
// One cursor axis: adds a signed delta to the position and clamps it to the screen.
// Depends on mpct_pkg.
module mpct_axis_step
  import mpct_pkg::*;
(
  input  logic [POS_W-1:0]          pos_i,
  input  logic signed [DELTA_W-1:0] delta_i,
  input  logic [POS_W-1:0]          screen_size_i,
  input  logic [POS_W-1:0]          cursor_size_i,
  output logic [POS_W-1:0]          pos_o
);

  logic signed [SUM_W-1:0] sum;
  logic [POS_W-1:0]        limit;

  // Upper limit is the screen size less the cursor, or zero for a tiny screen.
  assign limit = (screen_size_i > cursor_size_i) ? (screen_size_i - cursor_size_i) : '0;

  // Signed sum of position and delta, wide enough never to wrap.
  assign sum = $signed({2'b00, pos_i}) + SUM_W'(delta_i);

  // Clamp to zero below and to the limit above.
  always_comb begin
    if (sum < 0) begin
      pos_o = '0;
    end else if (sum > $signed({2'b00, limit})) begin
      pos_o = limit;
    end else begin
      pos_o = sum[POS_W-1:0];
    end
  end

endmodule

// ----- rtl/mouse_packet_cursor_tracker_core.sv -----
// Top level of the mouse packet cursor tracker.
// Depends on mpct_pkg and mpct_axis_step.
//
// Use of the block:
// The input stream carries one controller status byte and one data byte per
// transfer (in_tdata: ctrl_status in bits 7:0, data_byte in bits 15:8). Bytes
// whose status lacks data ready or the auxiliary device flag are dropped.
// Accepted bytes build three-byte packets; a packet whose header has the sync
// bit set moves the cursor by the signed X delta and the negated Y delta, and
// the clamped position leaves as one transfer on the output stream
// (out_tdata: cursor_x in bits 9:0, cursor_y in bits 19:10, rest zero).
// The configuration channel writes the screen width (index 0) and height
// (index 1); it is always ready and should be used while the block is idle.
// An input byte passes the single input register, the add-and-clamp logic and
// then the single result register; one input byte can be taken every cycle
// while the receiver keeps up with the results.
// A synchronous low rst_n empties both registers, clears the packet count and
// returns the cursor to 160, 100 on a 320 by 200 screen.
// If the receiver stalls, the result is held and the input register fills,
// after which in_tready drops until the result is taken.
module mouse_packet_cursor_tracker_core
  import mpct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream. in_tdata: ctrl_status [7:0], data_byte [15:8].
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream. out_tdata: cursor_x [9:0], cursor_y [19:10], zero fill above.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [POS_W-1:0]       cfg_data
);

  // Input register.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_status_r;
  logic [BYTE_W-1:0] s1_data_r;

  // Packet and cursor state.
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] header_r, header_nxt;
  logic [BYTE_W-1:0] delta_x_r, delta_x_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic [POS_W-1:0]  screen_w_r, screen_h_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_x_r, out_y_r;

  logic                      advance;
  logic                      take;
  logic                      emit;
  logic signed [DELTA_W-1:0] dx, dy_neg;
  logic [POS_W-1:0]          new_x, new_y;

  // The input register moves on whenever the result register is free or draining.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_status_r <= in_tdata[BYTE_W-1:0];
      s1_data_r   <= in_tdata[2*BYTE_W-1:BYTE_W];
    end
  end

  // A byte counts only with data ready and auxiliary device both flagged.
  assign take = s1_valid_r && advance
                && s1_status_r[STAT_READY_BIT] && s1_status_r[STAT_AUX_BIT];

  // Deltas: X as received, Y negated; nine bits hold the negated minimum.
  assign dx     = DELTA_W'($signed(delta_x_r));
  assign dy_neg = -DELTA_W'($signed(s1_data_r));

  mpct_axis_step u_step_x (
    .pos_i         (pos_x_r),
    .delta_i       (dx),
    .screen_size_i (screen_w_r),
    .cursor_size_i (CURSOR_W),
    .pos_o         (new_x)
  );

  mpct_axis_step u_step_y (
    .pos_i         (pos_y_r),
    .delta_i       (dy_neg),
    .screen_size_i (screen_h_r),
    .cursor_size_i (CURSOR_H),
    .pos_o         (new_y)
  );

  // Packet assembly: header, X delta, then Y delta completes the packet.
  always_comb begin
    byte_count_nxt = byte_count_r;
    header_nxt     = header_r;
    delta_x_nxt    = delta_x_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    emit           = 1'b0;
    if (take) begin
      case (byte_count_r)
        CNT_HEADER: begin
          header_nxt     = s1_data_r;
          byte_count_nxt = CNT_DX;
        end
        CNT_DX: begin
          delta_x_nxt    = s1_data_r;
          byte_count_nxt = CNT_DX + CNT_W'(1);
        end
        default: begin
          byte_count_nxt = CNT_HEADER;
          if (header_r[HDR_SYNC_BIT]) begin
            pos_x_nxt = new_x;
            pos_y_nxt = new_y;
            emit      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= CNT_HEADER;
      header_r     <= '0;
      delta_x_r    <= '0;
      pos_x_r      <= POS_X_RST;
      pos_y_r      <= POS_Y_RST;
    end else begin
      byte_count_r <= byte_count_nxt;
      header_r     <= header_nxt;
      delta_x_r    <= delta_x_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
    end
  end

  // Screen size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= WIDTH_RST;
      screen_h_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: screen_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register: loads on a completed sync packet, clears after its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r <= new_x;
      out_y_r <= new_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_y_r, out_x_r});

endmodule

// ----- rtl/mpct_checker.sv -----
// Port-level checks for the mouse packet cursor tracker, bound to the top level.
// Depends on mpct_pkg and mouse_packet_cursor_tracker_core.
module mpct_checker
  import mpct_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered with the same data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A fresh result follows an input transfer through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(rst_n, 2) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transfer");

  // Clamped cursor never exceeds the largest screen less the cursor.
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[POS_W-1:0] <= POS_W'(1015))
    else $error("cursor_x beyond its range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*POS_W-1:POS_W] <= POS_W'(1011))
    else $error("cursor_y beyond its range");

endmodule

bind mouse_packet_cursor_tracker_core mpct_checker u_mpct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
